// ===== design/bpq_pkg.sv =====
// shared types and constants of the bounded priority queue
package bpq_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int VALUE_W    = 32;
    localparam int PRIO_W     = 8;
    localparam int STATUS_W   = 2;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t item;
    } cmd_t;

endpackage

// ===== design/bpq_cell.sv =====
// one slot of the sorted chain: insert by priority, shift toward the head on removal
module bpq_cell
(
    input  logic           clk,
    input  bpq_pkg::cmd_t  cmd,
    input  logic           valid,
    input  logic           left_stay,
    input  bpq_pkg::entry_t left_data,
    input  bpq_pkg::entry_t right_data,
    output bpq_pkg::entry_t data,
    output logic           stay
);

    bpq_pkg::entry_t data_reg;
    bpq_pkg::entry_t data_next;

    // entry stays put on insert when it is served no later than the new one
    assign stay = valid && (data_reg.prio >= cmd.item.prio);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.enq)
        begin
            if (stay)
            begin
                data_next = data_reg;
            end
            else if (left_stay)
            begin
                data_next = cmd.item;
            end
            else
            begin
                data_next = left_data;
            end
        end
        else if (cmd.deq)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== design/bounded_priority_queue.sv =====
// top level of the bounded priority queue built as a sorted chain of cells
//
// A command beat is taken at a rising edge with start high and busy low.
// action low enqueues item_value with item_priority; action high dequeues the
// entry of highest priority, the oldest among equal priorities.
// Every command gives one result beat: done is high for exactly one cycle,
// the cycle right after the command, with status, out_value and occupancy.
// busy is high during that result cycle, so the block takes no new command until
// the result beat of the last one is shown; the chain itself settles in the
// cycle after acceptance, as every cell compares its own priority with
// the broadcast item and moves data one slot at most.
// An enqueue on a full queue gives overflow and leaves the queue unchanged;
// a dequeue on an empty queue gives underflow. out_value is zero except on a
// successful dequeue.
// Reset empties the queue and drops any pending result; entry contents are
// not cleared, the fill count alone marks which slots hold data.
// The receiver cannot stall: a result beat is shown once and not held.
module bounded_priority_queue
#(
    parameter int SLOTS = bpq_pkg::SLOTS_DEF,
    localparam int CW   = $clog2(SLOTS + 1)
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 action,
    input  logic signed [bpq_pkg::VALUE_W-1:0]   item_value,
    input  logic        [bpq_pkg::PRIO_W-1:0]    item_priority,
    output logic                                 done,
    output logic        [bpq_pkg::STATUS_W-1:0]  status,
    output logic signed [bpq_pkg::VALUE_W-1:0]   out_value,
    output logic        [CW-1:0]                 occupancy
);

    localparam logic [CW-1:0] FULL = CW'(SLOTS);

    logic                                count_reg;
    logic [CW-1:0]                       cnt_reg;
    logic [CW-1:0]                       cnt_next;
    logic                                done_reg;
    logic [bpq_pkg::STATUS_W-1:0]        status_reg;
    logic [bpq_pkg::STATUS_W-1:0]        status_next;
    logic signed [bpq_pkg::VALUE_W-1:0]  out_value_reg;
    logic signed [bpq_pkg::VALUE_W-1:0]  out_value_next;
    logic [CW-1:0]                       occupancy_reg;

    logic            accept;
    logic            is_full;
    logic            is_empty;
    bpq_pkg::cmd_t   cmd;
    bpq_pkg::entry_t cell_data [SLOTS];
    logic [SLOTS-1:0] cell_stay;
    logic [SLOTS-1:0] cell_valid;

    assign accept   = start && !busy;
    assign is_full  = (cnt_reg == FULL);
    assign is_empty = (cnt_reg == '0);

    assign cmd.enq        = accept && (action == bpq_pkg::ACT_ENQ) && !is_full;
    assign cmd.deq        = accept && (action == bpq_pkg::ACT_DEQ) && !is_empty;
    assign cmd.item.value = item_value;
    assign cmd.item.prio  = item_priority;

    // slot i holds data when it lies below the fill count
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            cell_valid[i] = (CW'(i) < cnt_reg);
        end
    end

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        bpq_pkg::entry_t left_d;
        bpq_pkg::entry_t right_d;
        logic            left_s;

        if (g == 0)
        begin : g_head
            assign left_s = 1'b1;
            assign left_d = cmd.item;
        end
        else
        begin : g_body
            assign left_s = cell_stay[g-1];
            assign left_d = cell_data[g-1];
        end

        if (g == SLOTS - 1)
        begin : g_tail
            assign right_d = cell_data[g];
        end
        else
        begin : g_inner
            assign right_d = cell_data[g+1];
        end

        bpq_cell u_cell
        (
            .clk        (clk),
            .cmd        (cmd),
            .valid      (cell_valid[g]),
            .left_stay  (left_s),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g]),
            .stay       (cell_stay[g])
        );
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        status_next    = bpq_pkg::ST_OK;
        out_value_next = '0;
        if (action == bpq_pkg::ACT_ENQ)
        begin
            if (is_full)
            begin
                status_next = bpq_pkg::ST_OVERFLOW;
            end
            else
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = bpq_pkg::ST_UNDERFLOW;
            end
            else
            begin
                cnt_next       = cnt_reg - CW'(1);
                out_value_next = cell_data[0].value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            count_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= accept;
            count_reg <= accept && (cmd.enq || cmd.deq);
            if (accept)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_value_reg <= out_value_next;
            occupancy_reg <= cnt_next;
        end
    end

    assign busy      = done_reg;
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_value = out_value_reg;
    assign occupancy = occupancy_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL)
        else $error("fill count beyond capacity");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done && !accept)
        else $error("result beat missing after command");

    a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> occupancy == cnt_reg)
        else $error("reported occupancy differs from fill count");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == bpq_pkg::ST_OK) |-> count_reg && $past(cnt_reg) != cnt_reg)
        else $error("successful command left fill count unchanged");

endmodule

// ===== test/tb_bounded_priority_queue.sv =====
// self-checking testbench of the bounded priority queue: directed table, then random op mixes
`timescale 1ns / 100ps

module tb_bounded_priority_queue;

    import bpq_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int CW          = $clog2(SLOTS + 1);
    localparam int RANDOM_OPS  = 1150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value;
        logic [CW-1:0]             occupancy;
    } queue_result_t;

    typedef struct packed {
        logic                      act;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        logic                      typed;
        queue_result_t             want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       action = ACT_ENQ;
    logic signed [VALUE_W-1:0]  item_value = '0;
    logic [PRIO_W-1:0]          item_priority = '0;
    logic                       busy;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  out_value;
    logic [CW-1:0]              occupancy;

    entry_t        held_entries[$];
    queue_result_t pending_results[$];
    stim_row_t     directed_rows[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;

    bounded_priority_queue #(.SLOTS(SLOTS)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .item_value    (item_value),
        .item_priority (item_priority),
        .done          (done),
        .status        (status),
        .out_value     (out_value),
        .occupancy     (occupancy)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bounded_priority_queue verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got %h want %h", $time, field, got, want);
    endtask

    // highest priority wins, strict compare keeps the oldest among equals
    function automatic queue_result_t predict_queue_op(input logic act,
                                                       input logic signed [VALUE_W-1:0] v,
                                                       input logic [PRIO_W-1:0] p);
        queue_result_t r;
        entry_t        e;
        int            best;
        r.status = ST_OK;
        r.value  = '0;
        if (act == ACT_ENQ)
        begin
            if (held_entries.size() >= SLOTS)
                r.status = ST_OVERFLOW;
            else
            begin
                e.value = v;
                e.prio  = p;
                held_entries.push_back(e);
            end
        end
        else if (held_entries.size() == 0)
            r.status = ST_UNDERFLOW;
        else
        begin
            best = 0;
            for (int i = 1; i < held_entries.size(); i++)
                if (held_entries[i].prio > held_entries[best].prio)
                    best = i;
            r.value = held_entries[best].value;
            held_entries.delete(best);
        end
        r.occupancy = CW'(held_entries.size());
        return r;
    endfunction

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("beat with nothing pending, status", 32'(status), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (out_value !== want.value)
                    report_mismatch("out_value", out_value, want.value);
                if (occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(occupancy), 32'(want.occupancy));
            end
        end
    end

    task automatic add_row(input logic act, input logic signed [VALUE_W-1:0] v,
                           input logic [PRIO_W-1:0] p, input logic typed,
                           input logic [STATUS_W-1:0] st, input logic signed [VALUE_W-1:0] ov,
                           input int occ);
        stim_row_t row;
        row.act            = act;
        row.value          = v;
        row.prio           = p;
        row.typed          = typed;
        row.want.status    = st;
        row.want.value     = ov;
        row.want.occupancy = CW'(occ);
        directed_rows.push_back(row);
    endtask

    task automatic issue_op(input stim_row_t row, input int gap);
        queue_result_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        action        <= row.act;
        item_value    <= row.value;
        item_priority <= row.prio;
        do @(posedge clk); while (busy);
        predicted = predict_queue_op(row.act, row.value, row.prio);
        pending_results.push_back(row.typed ? row.want : predicted);
    endtask

    task automatic hold_until_drained;
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        stim_row_t        row;
        logic [PRIO_W-1:0] prio_pattern[4];
        int               issued;
        int               phase_len;
        int               enq_pct;
        bit               narrow_prio;
        bit               no_gaps;

        prio_pattern = '{8'h00, 8'hFF, 8'h80, 8'h01};

        // empty dequeue, value and priority extremes, ties, dequeues, then fill to overflow and dequeue once more
        add_row(ACT_DEQ, 32'sh1234_5678, 8'hFF, 1'b1, ST_UNDERFLOW, '0, 0);
        add_row(ACT_ENQ, 32'sh8000_0000, 8'h00, 1'b1, ST_OK, '0, 1);
        add_row(ACT_ENQ, 32'sh7FFF_FFFF, 8'hFF, 1'b1, ST_OK, '0, 2);
        add_row(ACT_ENQ, 32'sh0000_0000, 8'hFF, 1'b1, ST_OK, '0, 3);
        add_row(ACT_ENQ, -32'sd1,        8'h80, 1'b1, ST_OK, '0, 4);
        add_row(ACT_DEQ, 32'sh0,         8'h00, 1'b1, ST_OK, 32'sh7FFF_FFFF, 3);
        add_row(ACT_DEQ, -32'sd1,        8'hFF, 1'b1, ST_OK, 32'sh0000_0000, 2);
        for (int k = 0; k < SLOTS - 2; k++)
            add_row(ACT_ENQ, (32'sh1000_0000 * k) ^ 32'sh5A5A_A5A5, prio_pattern[k % 4],
                    1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQ, 32'sh0BAD_F00D, 8'hFF, 1'b1, ST_OVERFLOW, '0, SLOTS);
        add_row(ACT_DEQ, 32'sh0,         8'h00, 1'b0, ST_OK, '0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_op(directed_rows[i], (i % 3 == 0) ? 0 : $urandom_range(0, 10));
        hold_until_drained();

        issued = 0;
        while (issued < RANDOM_OPS)
        begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       enq_pct = 20;
                1:       enq_pct = 50;
                default: enq_pct = 80;
            endcase
            narrow_prio = ($urandom_range(0, 1) == 1);
            no_gaps     = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_len && issued < RANDOM_OPS; n++)
            begin
                row.act   = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
                row.value = $urandom;
                if ($urandom_range(0, 15) == 0)
                    row.value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                row.prio  = narrow_prio ? PRIO_W'($urandom_range(0, 3))
                                        : PRIO_W'($urandom_range(0, 255));
                row.typed = 1'b0;
                row.want  = '0;
                issue_op(row, no_gaps ? 0 : $urandom_range(0, 10));
                issued++;
            end
            // pause the sender until every result of the phase is back
            hold_until_drained();
        end

        hold_until_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("bounded_priority_queue verification clean");
        else
            $display("bounded_priority_queue verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/bpq_pkg.sv
design/bpq_cell.sv
design/bounded_priority_queue.sv
test/tb_bounded_priority_queue.sv
